>>> rtl/mbce_pkg.sv
// Shared types and constants for the mono bitmap color expander.
// Used by mbce_front, mbce_back and the top level; no dependencies.
`default_nettype none

package mbce_pkg;

    localparam int BYTE_W         = 8;
    localparam int COLOR_W        = 16;
    localparam int DIM_W          = 11;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FORE_COLOR   = 2'd0,
        CFG_BACK_COLOR   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } cfg_t;

    // head of the byte queue as seen by the back end
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_q_t;

endpackage

`default_nettype wire

>>> rtl/mbce_front.sv
// Front end: accepts bitmap bytes and holds them in a two-entry queue.
// Depends on mbce_pkg.
`default_nettype none

module mbce_front
    import mbce_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] bitmap_byte
    output byte_q_t                q_head,
    input  wire logic              q_pop
);

    logic [BYTE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;

    assign s_tready    = (count_reg != 2'(QUEUE_DEPTH));
    assign push        = s_tvalid && s_tready;
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_tdata;
        end
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'(QUEUE_DEPTH)) && !q_pop |=> count_reg == 2'(QUEUE_DEPTH))
        else $error("full queue lost an entry");
`endif

endmodule

`default_nettype wire

>>> rtl/mbce_back.sv
// Back end: shifts each queued byte out MSB first, one pixel per cycle unless the sink stalls,
// tracks column and row, and drives the registered pixel output. Depends on mbce_pkg.
`default_nettype none

module mbce_back
    import mbce_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire byte_q_t            q_head,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [COLOR_W-1:0]      m_tdata,  // [15:0] pixel
    output logic                    m_tlast,  // image_end
    output logic [1:0]              m_tuser   // [0] row_end, [1] byte_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [2:0]         bit_idx_reg, bit_idx_next;
    logic               busy_reg, busy_next;
    logic               ov_reg, ov_next;
    logic [COLOR_W-1:0] pixel_reg;
    logic               row_end_reg, image_end_reg, byte_last_reg;

    int                 width_clamped, height_clamped;
    logic [CW-1:0]      last_col;
    logic [RW-1:0]      last_row;
    logic               rend, iend, blast, step, load;

    // zero counts as one, oversize saturates
    always_comb begin
        if (cfg.image_width == '0) begin
            width_clamped = 1;
        end else if (32'(cfg.image_width) > MAX_WIDTH) begin
            width_clamped = MAX_WIDTH;
        end else begin
            width_clamped = 32'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            height_clamped = 1;
        end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
            height_clamped = MAX_HEIGHT;
        end else begin
            height_clamped = 32'(cfg.image_height);
        end
        last_col = CW'(width_clamped - 1);
        last_row = RW'(height_clamped - 1);
    end

    assign rend  = (col_reg >= last_col);
    assign iend  = rend && (row_reg >= last_row);
    assign blast = rend || (bit_idx_reg == 3'd7);
    assign step  = busy_reg && (!ov_reg || m_tready);
    // fetch the next byte as the current one finishes, so pixels flow without a gap
    assign load  = q_head.valid && (!busy_reg || (step && blast));
    assign q_pop = load;

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        shift_next   = shift_reg;
        bit_idx_next = bit_idx_reg;
        busy_next    = busy_reg;
        if (step) begin
            shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
            bit_idx_next = bit_idx_reg + 3'd1;
            if (rend) begin
                col_next = '0;
                row_next = iend ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
            if (blast) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            shift_next   = q_head.data;
            bit_idx_next = 3'd0;
            busy_next    = 1'b1;
        end
    end

    always_comb begin
        ov_next = ov_reg;
        if (step) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            bit_idx_reg <= 3'd0;
            busy_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            bit_idx_reg <= bit_idx_next;
            busy_reg    <= busy_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (step) begin
            pixel_reg     <= shift_reg[BYTE_W-1] ? cfg.fore_color : cfg.back_color;
            row_end_reg   <= rend;
            image_end_reg <= iend;
            byte_last_reg <= blast;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = pixel_reg;
    assign m_tlast  = image_end_reg;
    assign m_tuser  = {byte_last_reg, row_end_reg};

`ifndef ASSERT_OFF
    a_image_end_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("image end without row end");
    a_row_end_ends_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("row end without byte_last");
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        step && rend |=> col_reg == '0)
        else $error("column did not wrap at row end");
    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        step && iend |=> row_reg == '0)
        else $error("row did not wrap at image end");
`endif

endmodule

`default_nettype wire

>>> rtl/mono_bitmap_color_expand_unit.sv
// Expands a 1-bpp bitmap stream into RGB565 pixels, one byte in, up to
// eight pixels out. A two-entry byte queue (front) feeds the serializer that
// shifts the byte out MSB first (back), and a registered output stage holds
// each pixel until the sink takes it. The back end emits one pixel per cycle
// unless the sink stalls; a full byte yields eight pixels, the last byte of a
// row only those left in the row; bytes are fetched from the queue in
// the cycle the previous one finishes, so pixels stream without gaps. Padding
// bits past the row width are dropped; column and row counters wrap after the
// last pixel of the image. Width/height of zero count as one, larger values
// saturate at MAX_WIDTH/MAX_HEIGHT. Configure only while the unit is idle.
// Depends on mbce_pkg, mbce_front and mbce_back.
`default_nettype none

module mono_bitmap_color_expand_unit
    import mbce_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] bitmap_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [COLOR_W-1:0]         m_tdata,   // [15:0] pixel
    output logic                       m_tlast,   // image_end
    output logic [1:0]                 m_tuser    // [0] row_end, [1] byte_last
);

    cfg_t    cfg_reg;
    byte_q_t q_head;
    logic    q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fore_color   <= '1;
            cfg_reg.back_color   <= '0;
            cfg_reg.image_width  <= DIM_W'(8);
            cfg_reg.image_height <= DIM_W'(8);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_FORE_COLOR:   cfg_reg.fore_color   <= cfg_wdata;
                CFG_BACK_COLOR:   cfg_reg.back_color   <= cfg_wdata;
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    mbce_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    mbce_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> tb/tb_mono_bitmap_color_expand_unit.sv
// Self-checking testbench for mono_bitmap_color_expand_unit: drives bitmap bytes and register
// writes, predicts every RGB565 pixel with its row/image/byte flags, and checks each transfer.
// Depends on mbce_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_mono_bitmap_color_expand_unit;
    import mbce_pkg::*;

    typedef struct {
        bit [COLOR_W-1:0] pixel;
        bit               row_end;
        bit               image_end;
        bit               byte_last;
    } pixel_exp_t;

    class pixel_scoreboard;
        bit [COLOR_W-1:0] fore;
        bit [COLOR_W-1:0] back;
        bit [DIM_W-1:0]   width;
        bit [DIM_W-1:0]   height;
        bit [9:0]         col;
        bit [9:0]         row;
        pixel_exp_t       pixel_q[$];
        int               mismatches;

        function new();
            fore       = 16'hFFFF;
            back       = 16'h0000;
            width      = 11'd8;
            height     = 11'd8;
            col        = '0;
            row        = '0;
            mismatches = 0;
        endfunction

        function bit [DIM_W-1:0] clamp_dim(bit [DIM_W-1:0] v, int maxv);
            if (v == 0)
                return DIM_W'(1);
            if (v > maxv)
                return DIM_W'(maxv);
            return v;
        endfunction

        function void set_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FORE_COLOR:   fore = val;
                CFG_BACK_COLOR:   back = val;
                CFG_IMAGE_WIDTH:  width = val[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height = val[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Expand one accepted byte into its pixels, MSB first; stop at the row end.
        function void note_byte(bit [BYTE_W-1:0] b);
            bit [9:0]         last_col;
            bit [9:0]         last_row;
            bit [BYTE_W-1:0]  bits;
            bit               rend;
            pixel_exp_t       e;
            last_col = 10'(clamp_dim(width, DEF_MAX_WIDTH) - 1);
            last_row = 10'(clamp_dim(height, DEF_MAX_HEIGHT) - 1);
            bits = b;
            for (int i = 0; i < 8; i++) begin
                rend        = (col >= last_col);
                e.pixel     = bits[7] ? fore : back;
                e.row_end   = rend;
                e.image_end = rend && (row >= last_row);
                e.byte_last = rend || (i == 7);
                pixel_q.push_back(e);
                bits = bits << 1;
                if (rend) begin
                    col = '0;
                    row = e.image_end ? 10'd0 : row + 10'd1;
                    break;
                end
                col = col + 10'd1;
            end
        endfunction

        function void check_pixel(bit [COLOR_W-1:0] pix, bit iend, bit [1:0] user);
            pixel_exp_t e;
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h row_end %b image_end %b byte_last %b",
                             pix, user[0], iend, user[1]);
                return;
            end
            e = pixel_q.pop_front();
            if (e.pixel !== pix || e.row_end !== user[0] || e.image_end !== iend ||
                e.byte_last !== user[1]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b (pix/row/img/byte)",
                             e.pixel, e.row_end, e.image_end, e.byte_last,
                             pix, user[0], iend, user[1]);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [COLOR_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    int send_idle = 17;
    int recv_idle = 59;
    int sent      = 0;

    pixel_scoreboard sb = new();

    mono_bitmap_color_expand_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hold valid across back-to-back transfers; drop it only for an idle gap.
    task automatic push_byte(input bit [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pixel_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input bit [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input bit [15:0] f, input bit [15:0] b,
                             input bit [15:0] w, input bit [15:0] h);
        settle();
        write_reg(CFG_FORE_COLOR, f);
        write_reg(CFG_BACK_COLOR, b);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bit [BYTE_W-1:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] rand_color();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small widths; now and then zero, saturating or wide ones. Upper bits are junk.
    function automatic bit [15:0] pick_width();
        bit [DIM_W-1:0] w;
        case ($urandom_range(9))
            0:       w = 11'd0;
            1:       w = 11'd1;
            2:       w = DIM_W'($urandom_range(1024, 2047));
            3:       w = DIM_W'($urandom_range(25, 1024));
            default: w = DIM_W'($urandom_range(2, 24));
        endcase
        return {5'($urandom), w};
    endfunction

    function automatic bit [15:0] pick_height();
        bit [DIM_W-1:0] h;
        case ($urandom_range(9))
            0:       h = 11'd0;
            1:       h = DIM_W'($urandom_range(1024, 2047));
            2:       h = DIM_W'($urandom_range(6, 1024));
            default: h = DIM_W'($urandom_range(1, 5));
        endcase
        return {5'($urandom), h};
    endfunction

    // Sink side: check on each transfer, then pick next cycle's ready.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_pixel(m_tdata, m_tlast, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int n;
        int img;
        bit [15:0] w;
        bit [15:0] h;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_FORE_COLOR;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry 8x8: full rows, extreme patterns.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h01);
        push_byte(8'hAA);
        push_byte(8'h55);

        // Narrow rows drop padding bits; the first byte closes the open image, the second starts a fresh one.
        configure(16'hF800, 16'h07E0, 16'd3, 16'd2);
        push_byte(8'hA0);
        push_byte(8'hFF);
        push_byte(8'h00);

        // Zero dimensions count as one pixel, one row.
        configure(16'h0000, 16'hFFFF, 16'd0, 16'd0);
        push_byte(8'hFF);
        push_byte(8'h00);

        // Oversized dimensions saturate.
        configure(16'h1234, 16'hABCD, 16'd2047, 16'd2047);
        push_byte(8'h5A);
        push_byte(8'hC3);
        push_byte(8'h3C);

        // Shrink width mid-row: column already past the end closes the row at once.
        configure(16'hFFFF, 16'h0000, 16'd10, 16'd2047);
        push_byte(8'hC3);
        // Row is now past a one-row height: the next row end closes the image.
        configure(16'hFFFF, 16'h0000, 16'd1024, 16'd1);
        push_byte(8'h81);
        configure(16'h8001, 16'h7FFE, 16'd9, 16'd1);
        push_byte(8'h7E);
        push_byte(8'hE7);

        configure(16'h001F, 16'hFFE0, 16'd1, 16'd3);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'hFF);
        push_byte(8'h00);

        while (sent < 260) begin
            if (sent >= 173) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (sent >= 87) begin
                send_idle = 59;
                recv_idle = 17;
            end
            w = pick_width();
            h = pick_height();
            configure(rand_color(), rand_color(), w, h);
            img = ((int'(sb.clamp_dim(w[DIM_W-1:0], DEF_MAX_WIDTH)) + 7) / 8) *
                  int'(sb.clamp_dim(h[DIM_W-1:0], DEF_MAX_HEIGHT));
            // Mostly whole images; otherwise a partial one left open for the next phase.
            n = ($urandom_range(3) != 0 && img <= 48) ? img : $urandom_range(1, 24);
            if (n > 260 - sent)
                n = 260 - sent;
            repeat (n) push_byte(rand_byte());
        end

        settle();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pixel_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mbce_pkg.sv
rtl/mbce_front.sv
rtl/mbce_back.sv
rtl/mono_bitmap_color_expand_unit.sv
tb/tb_mono_bitmap_color_expand_unit.sv
